>>> src/tfc_pkg.sv
// Types, codes and constants for the thermal fan controller.
// No dependencies; imported by every module of the block.
package tfc_pkg;

  localparam int TempW   = 8;
  localparam int LimitW  = 10;
  localparam int DivSteps = 8;
  localparam int StepW   = $clog2(DivSteps);
  localparam logic [7:0]  FULL_DUTY = 8'hFF;
  localparam logic [9:0]  COUNT_MAX = 10'h3FF;

  typedef enum logic [1:0] {
    REG_LOW   = 2'd0,
    REG_MID   = 2'd1,
    REG_HIGH  = 2'd2,
    REG_LIMIT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_EMERGENCY = 2'd1,
    MODE_ABNORMAL  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic [TempW-1:0] temperature;
    logic             btn_level;
  } in_beat_t;

  typedef struct packed {
    logic             fan_enable;
    logic [7:0]       fan_duty;
    logic             shutdown_request;
    logic [1:0]       mode;
  } out_beat_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> src/tfc_ctrl.sv
// Sequencer for the thermal fan controller: capture, divider load,
// eight divider steps, result write. Uses tfc_pkg.
module tfc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tfc_pkg::dp_status_t status,
  output tfc_pkg::dp_cmd_t    cmd
);
  import tfc_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             last_step;

  assign last_step = (step_r == StepW'(DivSteps - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
        step_nxt  = '0;
      end
      ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (last_step) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOAD: cmd.load = 1'b1;
      ST_DIV:  cmd.step = 1'b1;
      ST_FIN:  cmd.finish = status.out_free;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_capture_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == ST_LOAD)
    else $error("capture not followed by load");
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && last_step) |=> state_r == ST_FIN)
    else $error("divider did not finish after last step");
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !status.out_free) |=> state_r == ST_FIN)
    else $error("result dropped while output slot busy");
`endif
endmodule

>>> src/tfc_dp.sv
// Datapath: threshold registers, sample capture, ramp numerator, restoring
// divider, mode machine and output register. Uses tfc_pkg.
module tfc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [9:0]           cfg_wdata,
  input  tfc_pkg::in_beat_t    in_data,
  output tfc_pkg::out_beat_t   out_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tfc_pkg::dp_cmd_t     cmd,
  output tfc_pkg::dp_status_t  status
);
  import tfc_pkg::*;

  logic [7:0]  low_r, mid_r, high_r;
  logic [9:0]  limit_r;
  logic [7:0]  temp_r;
  logic        button_r;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  quo_r, quo_nxt;
  mode_t       mode_r, mode_nxt;
  logic [9:0]  count_r, count_nxt, count_inc;
  out_beat_t   out_r, out_nxt;
  logic        out_valid_r;

  logic [7:0]  diff;
  logic [15:0] numer;
  logic [7:0]  span;
  logic [8:0]  shifted;
  logic        t_lt_low, t_lt_mid, t_lt_high;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= 8'd20;
      mid_r   <= 8'd40;
      high_r  <= 8'd50;
      limit_r <= 10'd14;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_LOW:   low_r   <= cfg_wdata[7:0];
        REG_MID:   mid_r   <= cfg_wdata[7:0];
        REG_HIGH:  high_r  <= cfg_wdata[7:0];
        REG_LIMIT: limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign t_lt_low  = temp_r < low_r;
  assign t_lt_mid  = temp_r < mid_r;
  assign t_lt_high = temp_r < high_r;

  // (t - low) * 255; quotient stays below 256, so the upper byte seeds the remainder
  assign diff    = temp_r - low_r;
  assign numer   = {diff, 8'h00} - {8'h00, diff};
  assign span    = mid_r - low_r;
  assign shifted = {rem_r, quo_r[7]};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.load) begin
      rem_nxt = numer[15:8];
      quo_nxt = numer[7:0];
    end else if (cmd.step) begin
      if (shifted >= {1'b0, span}) begin
        rem_nxt = 8'(shifted - {1'b0, span});
        quo_nxt = {quo_r[6:0], 1'b1};
      end else begin
        rem_nxt = shifted[7:0];
        quo_nxt = {quo_r[6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      temp_r   <= in_data.temperature;
      button_r <= in_data.btn_level;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    unique case (mode_r)
      MODE_NORMAL: begin
        if (!t_lt_high) begin
          mode_nxt  = MODE_EMERGENCY;
          count_nxt = '0;
        end
      end
      MODE_EMERGENCY: begin
        count_nxt = count_inc;
        if (count_inc >= limit_r) mode_nxt = MODE_ABNORMAL;
        else if (t_lt_high)       mode_nxt = MODE_NORMAL;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_nxt.shutdown_request = button_r && !t_lt_mid && t_lt_high;
    out_nxt.mode             = mode_nxt;
    if (mode_r == MODE_ABNORMAL) begin
      out_nxt.fan_enable = 1'b1;
      out_nxt.fan_duty   = FULL_DUTY;
    end else if (t_lt_low) begin
      out_nxt.fan_enable = 1'b0;
      out_nxt.fan_duty   = '0;
    end else if (t_lt_mid) begin
      out_nxt.fan_enable = 1'b1;
      out_nxt.fan_duty   = quo_r;
    end else begin
      out_nxt.fan_enable = 1'b1;
      out_nxt.fan_duty   = FULL_DUTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NORMAL;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        mode_r      <= mode_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_r <= out_nxt;
  end

  assign out_data        = out_r;
  assign out_valid       = out_valid_r;
  assign status.out_free = !out_valid_r || out_ready;

`ifndef ASSERT_OFF
  a_abnormal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_ABNORMAL |=> mode_r == MODE_ABNORMAL)
    else $error("abnormal mode left without reset");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result written over a pending beat");
  a_mode_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.finish |=> $stable(mode_r) && $stable(count_r))
    else $error("mode changed outside result write");
`endif
endmodule

>>> src/thermal_fan_controller.sv
// Thermal fan controller. Each sample passes through capture, load, the 8-step
// serial divider and the result write; a new sample is taken only after the
// result write, which waits while the output register still holds an untaken beat.
// Reset (rst_n, synchronous, active low): thresholds 20/40/50, limit 14,
// normal mode, count cleared, no result pending. Uses tfc_pkg, tfc_ctrl, tfc_dp.
module thermal_fan_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tfc_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tfc_pkg::out_beat_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [9:0]          cfg_wdata
);
  import tfc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tfc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );
endmodule

>>> test/tb_thermal_fan_controller.sv
// Self-checking testbench for thermal_fan_controller: directed threshold samples,
// then randomised threshold settings, with a fan/mode predictor and a beat scoreboard.
// Depends on tfc_pkg and the thermal_fan_controller RTL.
`timescale 1ns / 1ps

module tb_thermal_fan_controller;
  import tfc_pkg::*;

  localparam int QuietLimit = 5000;

  typedef struct packed {
    logic [7:0] low;
    logic [7:0] mid;
    logic [7:0] high;
    logic [9:0] limit;
  } thresholds_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] count;
  } fan_state_t;

  typedef struct packed {
    out_beat_t  drive;
    fan_state_t next;
  } fan_step_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_beat_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_addr = REG_LOW;
  logic [9:0] cfg_wdata = '0;

  thresholds_t fan_cfg = '{low: 8'd20, mid: 8'd40, high: 8'd50, limit: 10'd14};
  fan_state_t  gen_state = '0;
  fan_state_t  acc_state = '0;
  fan_step_t   acc_step;

  in_beat_t    samples_pending[$];
  out_beat_t   expected_drives[$];

  int          err_cnt = 0;
  int          n_sent = 0;
  int          n_settings = 1;
  int          max_depth = 0;
  int          drives_seen = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  bit          held = 1'b0;
  int unsigned rx_cyc = 0;
  int          quiet = 0;

  thermal_fan_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic fan_step_t predict_fan_step(thresholds_t th, in_beat_t s, fan_state_t st);
    fan_step_t   r;
    int unsigned t;
    int unsigned span;
    int unsigned q;
    t = s.temperature;
    r.next = st;
    r.drive.shutdown_request = s.btn_level && (t >= th.mid) && (t < th.high);
    if (t < th.low) begin
      r.drive.fan_enable = 1'b0;
      r.drive.fan_duty   = '0;
    end else if (t < th.mid) begin
      r.drive.fan_enable = 1'b1;
      if (th.mid <= th.low) begin
        r.drive.fan_duty = FULL_DUTY;
      end else begin
        span = th.mid - th.low;
        q = ((t - th.low) * 255) / span;
        r.drive.fan_duty = (q > 255) ? FULL_DUTY : q[7:0];
      end
    end else begin
      r.drive.fan_enable = 1'b1;
      r.drive.fan_duty   = FULL_DUTY;
    end
    case (st.mode)
      MODE_NORMAL: begin
        if (t >= th.high) begin
          r.next.mode  = MODE_EMERGENCY;
          r.next.count = '0;
        end
      end
      MODE_EMERGENCY: begin
        if (st.count != COUNT_MAX) r.next.count = st.count + 10'd1;
        if (r.next.count >= th.limit) r.next.mode = MODE_ABNORMAL;
        else if (t < th.high) r.next.mode = MODE_NORMAL;
      end
      MODE_ABNORMAL: begin
        r.drive.fan_enable = 1'b1;
        r.drive.fan_duty   = FULL_DUTY;
      end
      default: ;
    endcase
    r.drive.mode = r.next.mode;
    return r;
  endfunction

  // Biased towards the threshold bands; keeps clear of abnormal unless allowed.
  function automatic logic [7:0] pick_temp(bit hot, bit allow_abn);
    int t;
    int lo;
    int md;
    int hi;
    int sel;
    lo = fan_cfg.low;
    md = fan_cfg.mid;
    hi = fan_cfg.high;
    sel = hot ? 9 : $urandom_range(0, 9);
    case (sel)
      0, 1: t = $urandom_range(0, 255);
      2: t = (lo > 0) ? $urandom_range(0, lo - 1) : 0;
      3, 4: t = (md > lo) ? $urandom_range(lo, md - 1) : $urandom_range(0, 255);
      5: begin
        case ($urandom_range(0, 2))
          0: t = lo;
          1: t = md;
          default: t = hi;
        endcase
        t = t + $urandom_range(0, 2) - 1;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
      end
      6, 7: t = (hi > md) ? $urandom_range(md, hi - 1) : $urandom_range(0, 255);
      default: t = $urandom_range(hi, 255);
    endcase
    if (!allow_abn && t >= hi && hi > 0) begin
      if ((gen_state.mode == MODE_NORMAL && fan_cfg.limit < 3) ||
          (gen_state.mode == MODE_EMERGENCY && gen_state.count + 2 >= fan_cfg.limit))
        t = $urandom_range(0, hi - 1);
    end
    return t[7:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic push_sample(logic [7:0] t, logic b);
    in_beat_t  s;
    fan_step_t r;
    s.temperature = t;
    s.btn_level   = b;
    r = predict_fan_step(fan_cfg, s, gen_state);
    gen_state = r.next;
    samples_pending.push_back(s);
    n_sent++;
  endtask

  task automatic wait_idle();
    while (samples_pending.size() != 0 || in_valid || expected_drives.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int val);
    logic [9:0] w;
    w = val[9:0];
    if (idx != REG_LIMIT) w[9:8] = 2'($urandom_range(0, 3));
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOW:  fan_cfg.low  = w[7:0];
      REG_MID:  fan_cfg.mid  = w[7:0];
      REG_HIGH: fan_cfg.high = w[7:0];
      default:  fan_cfg.limit = w;
    endcase
  endtask

  task automatic set_thresholds(int lo, int md, int hi, int lim);
    write_reg(REG_LOW, lo);
    write_reg(REG_MID, md);
    write_reg(REG_HIGH, hi);
    write_reg(REG_LIMIT, lim);
    n_settings++;
  endtask

  task automatic run_phase(int n, bit allow_abn);
    int run_left;
    int cap;
    run_left = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0 && $urandom_range(0, 19) == 0) begin
        cap = (fan_cfg.limit + 2 > 60) ? 60 : fan_cfg.limit + 2;
        run_left = $urandom_range(1, cap);
      end
      push_sample(pick_temp(run_left != 0, allow_abn), 1'($urandom_range(0, 1)));
      if (run_left != 0) run_left--;
    end
  endtask

  // Sender: bursts with gaps, valid held until the beat is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        acc_step = predict_fan_step(fan_cfg, in_data, acc_state);
        acc_state <= acc_step.next;
        if (acc_step.next.count > max_depth) max_depth <= int'(acc_step.next.count);
        expected_drives.push_back(acc_step.drive);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (samples_pending.size() != 0) begin
          in_data  <= samples_pending.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: rotating stall pattern, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held && drives_seen >= 300) begin
        held      <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else begin
        case (rx_cyc[7:6])
          2'd0:    out_ready <= 1'b1;
          2'd1:    out_ready <= 1'($urandom_range(0, 1));
          2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= rx_cyc[2];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      drives_seen <= drives_seen + 1;
      if (expected_drives.size() == 0) begin
        report_mismatch("unexpected beat, mode", out_data.mode, -1);
      end else begin
        want = expected_drives.pop_front();
        if (out_data.fan_enable !== want.fan_enable)
          report_mismatch("fan_enable", out_data.fan_enable, want.fan_enable);
        if (out_data.fan_duty !== want.fan_duty)
          report_mismatch("fan_duty", out_data.fan_duty, want.fan_duty);
        if (out_data.shutdown_request !== want.shutdown_request)
          report_mismatch("shutdown_request", out_data.shutdown_request,
                          want.shutdown_request);
        if (out_data.mode !== want.mode)
          report_mismatch("mode", out_data.mode, want.mode);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("Timeout: no beat for %0d cycles", quiet);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int lo;
    int md;
    int hi;
    int lim;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds: band edges, shutdown window, emergency entry and exit
    push_sample(8'd0, 1'b0);
    push_sample(8'd0, 1'b1);
    push_sample(8'd19, 1'b1);
    push_sample(8'd20, 1'b0);
    push_sample(8'd21, 1'b1);
    push_sample(8'd30, 1'b0);
    push_sample(8'd39, 1'b1);
    push_sample(8'd40, 1'b1);
    push_sample(8'd49, 1'b1);
    push_sample(8'd50, 1'b1);
    push_sample(8'd51, 1'b0);
    push_sample(8'd255, 1'b1);
    push_sample(8'd10, 1'b1);
    push_sample(8'd50, 1'b0);
    push_sample(8'd128, 1'b1);
    push_sample(8'd0, 1'b0);
    wait_idle();

    // empty ramp and empty shutdown window
    set_thresholds(100, 100, 100, 3);
    push_sample(8'd99, 1'b1);
    push_sample(8'd100, 1'b1);
    push_sample(8'd255, 1'b1);
    push_sample(8'd0, 1'b0);
    wait_idle();

    set_thresholds(0, 255, 255, 1023);
    push_sample(8'd0, 1'b1);
    push_sample(8'd254, 1'b1);
    push_sample(8'd255, 1'b0);
    push_sample(8'd1, 1'b0);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          lo = $urandom_range(0, 80); md = lo + $urandom_range(1, 100);
          hi = md + $urandom_range(0, 60); lim = $urandom_range(3, 30);
        end
        1: begin
          lo = $urandom_range(0, 255); md = $urandom_range(0, lo);
          hi = $urandom_range(1, 255); lim = 3;
        end
        2: begin
          md = $urandom_range(50, 255); lo = $urandom_range(0, md - 1);
          hi = $urandom_range(1, md); lim = $urandom_range(3, 1023);
        end
        3: begin
          lo = $urandom_range(0, 100); md = lo + $urandom_range(0, 100);
          hi = md + $urandom_range(0, 55); lim = 1023;
        end
        4: begin
          lo = 255; md = 255; hi = 255; lim = $urandom_range(3, 10);
        end
        5: begin
          lo = $urandom_range(0, 255); md = $urandom_range(0, 255);
          hi = $urandom_range(1, 255); lim = $urandom_range(3, 1023);
        end
        default: begin
          lo = $urandom_range(0, 30); md = lo + $urandom_range(5, 60);
          hi = md + $urandom_range(1, 40); lim = $urandom_range(3, 5);
        end
      endcase
      if (hi > 255) hi = 255;
      if (md > 255) md = 255;
      set_thresholds(lo, md, hi, lim);
      run_phase(150, 1'b0);
      wait_idle();
    end

    // emergency run, then the limit is dropped to zero: latches abnormal
    set_thresholds(20, 40, 50, 500);
    push_sample(8'd200, 1'b0);
    for (int i = 0; i < 9; i++)
      push_sample(8'($urandom_range(50, 255)), 1'($urandom_range(0, 1)));
    wait_idle();
    write_reg(REG_LIMIT, 0);
    run_phase(60, 1'b1);
    wait_idle();
    set_thresholds($urandom_range(0, 255), $urandom_range(100, 255), $urandom_range(0, 99),
                   $urandom_range(0, 1023));
    run_phase(60, 1'b1);
    wait_idle();

    repeat (30) @(posedge clk);
    if (expected_drives.size() != 0)
      report_mismatch("drive beats never returned", 0, expected_drives.size());
    $display("Ran %0d samples over %0d threshold settings, %0d mismatches",
             n_sent, n_settings, err_cnt);
    $display("Deepest emergency count %0d; run ended in mode %0d", max_depth, acc_state.mode);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
